>>> src/ddo_pkg.sv
package ddo_pkg;

  localparam int unsigned FracBitsDefault    = 16;
  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned TableLen           = 24;

  localparam int unsigned DeltaW   = 20;
  localparam int unsigned BaseW    = 20;
  localparam int unsigned PosW     = 32;
  localparam int unsigned HeadW    = 19;
  localparam int unsigned DiffW    = 21;
  localparam int unsigned AngW     = 36;
  localparam int unsigned CordW    = 33;

  localparam logic [BaseW-1:0] WheelBaseReset = 20'd32768;
  localparam logic signed [AngW-1:0] PiQ32     = 36'sd13493037705;
  localparam logic signed [AngW-1:0] HalfPiQ32 = 36'sd6746518852;
  localparam logic signed [CordW-1:0] GainQ30  = 33'sd652032874;

  function automatic logic signed [AngW-1:0] atan_q32(input logic [4:0] idx);
    logic signed [AngW-1:0] v;
    begin
      case (idx)
        5'd0:  v = 36'sd3373259426;
        5'd1:  v = 36'sd1991351318;
        5'd2:  v = 36'sd1052175346;
        5'd3:  v = 36'sd534100635;
        5'd4:  v = 36'sd268086748;
        5'd5:  v = 36'sd134174063;
        5'd6:  v = 36'sd67103403;
        5'd7:  v = 36'sd33553749;
        5'd8:  v = 36'sd16777131;
        5'd9:  v = 36'sd8388597;
        5'd10: v = 36'sd4194303;
        5'd11: v = 36'sd2097152;
        5'd12: v = 36'sd1048576;
        5'd13: v = 36'sd524288;
        5'd14: v = 36'sd262144;
        5'd15: v = 36'sd131072;
        5'd16: v = 36'sd65536;
        5'd17: v = 36'sd32768;
        5'd18: v = 36'sd16384;
        5'd19: v = 36'sd8192;
        5'd20: v = 36'sd4096;
        5'd21: v = 36'sd2048;
        5'd22: v = 36'sd1024;
        5'd23: v = 36'sd512;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StDiv  = 6'b000010,
    StPrep = 6'b000100,
    StRot  = 6'b001000,
    StMul  = 6'b010000,
    StOut  = 6'b100000
  } ddo_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic prep;
    logic rot_step;
    logic mul;
    logic commit;
  } ddo_cmd_t;

  typedef struct packed {
    logic div_last;
    logic rot_last;
  } ddo_sts_t;

endpackage

>>> src/ddo_ctrl.sv
module ddo_ctrl import ddo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  ddo_sts_t sts_i,
  output ddo_cmd_t cmd_o
);

  ddo_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StPrep;
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = StRot;
      end
      StRot: begin
        cmd_o.rot_step = 1'b1;
        if (sts_i.rot_last) state_d = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        // hold until the previous result has left the output register
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (state_q == StIdle) && out_valid_q)
    else $error("commit did not present result");
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> in_ready_o)
    else $error("load without ready");
`endif

endmodule

>>> src/ddo_dp.sv
module ddo_dp import ddo_pkg::*; #(
  parameter int unsigned FRAC_BITS    = FracBitsDefault,
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [BaseW-1:0]         cfg_data_i,
  input  logic signed [DeltaW-1:0] delta_left_i,
  input  logic signed [DeltaW-1:0] delta_right_i,
  input  ddo_cmd_t                 cmd_i,
  output ddo_sts_t                 sts_o,
  output logic signed [PosW-1:0]   pos_x_o,
  output logic signed [PosW-1:0]   pos_y_o,
  output logic signed [FRAC_BITS+2:0] heading_o,
  output logic                     saturated_o
);

  localparam int unsigned Steps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
  localparam int unsigned NumW  = DiffW + FRAC_BITS;
  localparam int unsigned CntW  = $clog2(NumW + 1);
  localparam int unsigned SumW  = 21;
  localparam int unsigned PrdW  = SumW + CordW;
  localparam int unsigned HeadBits = FRAC_BITS + 3;
  localparam logic signed [AngW-1:0] PiQ =
    AngW'((PiQ32 + (36'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS));

  logic [BaseW-1:0]         wb_q;
  logic signed [SumW-1:0]   sum_q;
  logic                     neg_q;
  logic [NumW-1:0]          num_q;
  logic [BaseW-1:0]         rem_q;
  logic [CntW-1:0]          dcnt_q;
  logic [4:0]               rcnt_q;
  logic signed [AngW-1:0]   dth_q;
  logic                     sat_q;
  logic signed [CordW-1:0]  cx_q, cy_q;
  logic signed [AngW-1:0]   cz_q;
  logic                     cneg_q;
  logic signed [PrdW-1:0]   px_q, py_q;
  logic signed [PosW-1:0]   x_q, y_q;
  logic signed [HeadBits-1:0] th_q;
  logic                     osat_q;

  // restoring divide of |R-L| * 2^FRAC_BITS by wheel base, one bit a step
  logic [BaseW:0] rem_sh;
  logic [BaseW:0] rem_sub;
  assign rem_sh  = {rem_q, num_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, wb_q};

  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        adiff;
  assign diff  = DiffW'(delta_right_i) - DiffW'(delta_left_i);
  assign adiff = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);

  // heading change clamp, compared at the full quotient width
  logic signed [AngW-1:0] qmag, dth_c;
  logic                   clamp;
  assign clamp = (wb_q != '0) && (num_q > NumW'(PiQ));
  assign qmag  = (wb_q == '0) ? ((num_q == '0) ? '0 : PiQ)
                              : (clamp ? PiQ : AngW'(num_q));
  assign dth_c = neg_q ? -qmag : qmag;

  logic signed [AngW-1:0] mid;
  assign mid = (AngW'(th_q) <<< (32 - FRAC_BITS)) + (dth_c <<< (31 - FRAC_BITS));

  logic signed [CordW-1:0] xs, ys;
  logic signed [AngW-1:0]  at;
  assign xs = cx_q >>> rcnt_q;
  assign ys = cy_q >>> rcnt_q;
  assign at = atan_q32(rcnt_q);

  logic signed [CordW-1:0] cs, sn;
  assign cs = cneg_q ? -cx_q : cx_q;
  assign sn = cneg_q ? -cy_q : cy_q;

  // final pose arithmetic
  logic signed [PrdW-1:0]  dx, dy;
  logic signed [PosW+1:0]  nx, ny;
  logic signed [HeadBits+1:0] nth;
  logic                    sx, sy;
  assign dx  = (px_q + (PrdW'(1) <<< 30)) >>> 31;
  assign dy  = (py_q + (PrdW'(1) <<< 30)) >>> 31;
  assign nx  = (PosW+2)'(x_q) + (PosW+2)'(dx);
  assign ny  = (PosW+2)'(y_q) + (PosW+2)'(dy);
  assign sx  = (nx > (PosW+2)'(32'sh7fffffff)) || (nx < -(PosW+2)'(34'sh80000000));
  assign sy  = (ny > (PosW+2)'(32'sh7fffffff)) || (ny < -(PosW+2)'(34'sh80000000));
  assign nth = (HeadBits+2)'(th_q) + (HeadBits+2)'(dth_q);

  function automatic logic signed [PosW-1:0] sat32(input logic signed [PosW+1:0] v);
    begin
      if (v > (PosW+2)'(32'sh7fffffff)) return 32'sh7fffffff;
      else if (v < -(PosW+2)'(34'sh80000000)) return 32'sh80000000;
      else return v[PosW-1:0];
    end
  endfunction

  assign sts_o.div_last = (dcnt_q == CntW'(NumW - 1));
  assign sts_o.rot_last = (rcnt_q == 5'(Steps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= WheelBaseReset;
      x_q  <= '0;
      y_q  <= '0;
      th_q <= '0;
    end else begin
      if (cfg_we_i) wb_q <= cfg_data_i;
      if (cmd_i.commit) begin
        x_q <= sat32(nx);
        y_q <= sat32(ny);
        if (nth > (HeadBits+2)'(PiQ)) th_q <= HeadBits'(nth - 2 * (HeadBits+2)'(PiQ));
        else if (nth < -(HeadBits+2)'(PiQ)) th_q <= HeadBits'(nth + 2 * (HeadBits+2)'(PiQ));
        else th_q <= HeadBits'(nth);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q  <= SumW'(delta_left_i) + SumW'(delta_right_i);
      neg_q  <= diff[DiffW-1];
      num_q  <= NumW'(adiff) << FRAC_BITS;
      rem_q  <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (wb_q != '0) begin
        if (!rem_sub[BaseW]) begin
          rem_q <= rem_sub[BaseW-1:0];
          num_q <= {num_q[NumW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[BaseW-1:0];
          num_q <= {num_q[NumW-2:0], 1'b0};
        end
      end
    end
    if (cmd_i.prep) begin
      dth_q  <= dth_c;
      sat_q  <= clamp || ((wb_q == '0) && (num_q != '0));
      cx_q   <= GainQ30;
      cy_q   <= '0;
      rcnt_q <= '0;
      if (mid > HalfPiQ32) begin
        cz_q <= mid - PiQ32; cneg_q <= 1'b1;
      end else if (mid < -HalfPiQ32) begin
        cz_q <= mid + PiQ32; cneg_q <= 1'b1;
      end else begin
        cz_q <= mid; cneg_q <= 1'b0;
      end
    end
    if (cmd_i.rot_step) begin
      rcnt_q <= rcnt_q + 1'b1;
      if (!cz_q[AngW-1]) begin
        cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + at;
      end
    end
    if (cmd_i.mul) begin
      px_q <= PrdW'(sum_q) * PrdW'(cs);
      py_q <= PrdW'(sum_q) * PrdW'(sn);
    end
    if (cmd_i.commit) osat_q <= sat_q || sx || sy;
  end

  assign pos_x_o     = x_q;
  assign pos_y_o     = y_q;
  assign heading_o   = th_q;
  assign saturated_o = osat_q;

`ifndef ASSERT_OFF
  a_dth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.prep |=> (dth_q <= PiQ) && (dth_q >= -PiQ))
    else $error("heading change out of range");
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (th_q <= HeadBits'(PiQ)) && (th_q >= -HeadBits'(PiQ)))
    else $error("heading out of range");
  a_rcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.prep |=> rcnt_q == '0)
    else $error("rotation counter not cleared");
`endif

endmodule

>>> src/differential_drive_odometry.sv
// Differential-drive pose tracker. Each request carries left and right wheel
// travel (signed Q.FRAC_BITS m); the block divides the wheel difference by the
// wheel base register with a bit-serial restoring divider (21 + FRAC_BITS
// quotient bits), rotates the midpoint heading through an iterative CORDIC
// stage (CORDIC_STEPS iterations, at most 24), multiplies, then saturates
// x and y and wraps the heading into +-pi. Requests are processed one at a
// time. The result register lets a new request enter while the last pose
// waits; a pose that is still waiting when the next one is ready holds the
// block. The heading port is FRAC_BITS + 3 bits wide (Q3.FRAC_BITS radians).
// saturated_o flags a clamped heading change or a clipped position. Write the
// wheel base only while idle.
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int unsigned FRAC_BITS    = FracBitsDefault,
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [BaseW-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DeltaW-1:0] delta_left_i,
  input  logic signed [DeltaW-1:0] delta_right_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [PosW-1:0]   pos_x_o,
  output logic signed [PosW-1:0]   pos_y_o,
  output logic signed [FRAC_BITS+2:0] heading_o,
  output logic                     saturated_o
);

  ddo_cmd_t cmd;
  ddo_sts_t sts;

  // sequence the divide, rotation, multiply and commit steps
  ddo_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  // hold the pose and do the arithmetic
  ddo_dp #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .delta_left_i, .delta_right_i,
    .cmd_i(cmd), .sts_o(sts), .pos_x_o, .pos_y_o, .heading_o, .saturated_o
  );

endmodule
